>>> sv/lfr_pkg.sv
`default_nettype none

package lfr_pkg;

    // Default frame count and the fixed width of a frame number on the ports
    localparam int DEF_FRAME_CNT = 16;
    localparam int FRAME_W       = 4;

    // Action codes carried in the input word
    localparam logic ACT_ACCESS = 1'b0;
    localparam logic ACT_VICTIM = 1'b1;

endpackage

`default_nettype wire

>>> sv/lru_frame_replacement.sv
// Result path: a victim request passes through the input register, then the result register;
//   an access gives no result.
// Throughput: one word per cycle; the input stalls only while a victim request waits on
//   a result that the output side is holding back.
// Reset (synchronous, active low): frame f gets rank f, so frame 0 is least recent;
//   both valid flags clear.
`default_nettype none

module lru_frame_replacement #(
    parameter int FRAME_CNT = lfr_pkg::DEF_FRAME_CNT
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic                       i_action,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_frame_index,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [lfr_pkg::FRAME_W-1:0]     o_victim_frame
);
    import lfr_pkg::*;

    localparam int IDX_W = $clog2(FRAME_CNT);

    typedef logic [IDX_W-1:0] t_rank;

    // Recency state: rank 0 is least recent, FRAME_CNT-1 most recent
    t_rank r_rank [FRAME_CNT];
    t_rank n_rank [FRAME_CNT];

    // Input register
    logic                r_in_vld;
    logic                n_in_vld;
    logic                r_action;
    logic [FRAME_W-1:0]  r_frame;

    // Result register
    logic                r_out_vld;
    logic                n_out_vld;
    logic [FRAME_W-1:0]  r_victim;

    logic                in_acc;
    logic                out_free;
    logic                s1_go;
    logic                in_range;
    logic                do_move;
    t_rank               vic_idx;
    t_rank               tgt_idx;
    t_rank               old_rank;

    // Handshake
    assign out_free   = !r_out_vld || !i_out_stall;
    assign s1_go      = r_in_vld && ((r_action == ACT_ACCESS) || out_free);
    assign o_in_stall = r_in_vld && !s1_go;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Find the least recent frame (exactly one frame holds rank 0)
    always_comb begin
        vic_idx = '0;
        for (int f = 0; f < FRAME_CNT; f++) begin
            if (r_rank[f] == '0) begin
                vic_idx = vic_idx | t_rank'(f);
            end
        end
    end

    // Frame to move to most recent
    assign in_range = 32'(r_frame) < FRAME_CNT;
    assign tgt_idx  = (r_action == ACT_VICTIM) ? vic_idx : t_rank'(r_frame);
    assign do_move  = s1_go && ((r_action == ACT_VICTIM) || in_range);
    assign old_rank = r_rank[tgt_idx];

    // Rank update: frames more recent than the target slide down by one
    always_comb begin
        for (int g = 0; g < FRAME_CNT; g++) begin
            n_rank[g] = r_rank[g];
            if (do_move) begin
                if (t_rank'(g) == tgt_idx) begin
                    n_rank[g] = t_rank'(FRAME_CNT - 1);
                end else if (r_rank[g] > old_rank) begin
                    n_rank[g] = r_rank[g] - t_rank'(1);
                end
            end
        end
    end

    // Valid flags
    always_comb begin
        n_in_vld = r_in_vld;
        if (in_acc) begin
            n_in_vld = 1'b1;
        end else if (s1_go) begin
            n_in_vld = 1'b0;
        end

        n_out_vld = r_out_vld;
        if (s1_go && (r_action == ACT_VICTIM)) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int f = 0; f < FRAME_CNT; f++) begin
                r_rank[f] <= t_rank'(f);
            end
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            for (int f = 0; f < FRAME_CNT; f++) begin
                r_rank[f] <= n_rank[f];
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_action <= i_action;
            r_frame  <= i_frame_index;
        end
        if (s1_go && (r_action == ACT_VICTIM)) begin
            r_victim <= FRAME_W'(vic_idx);
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_victim_frame = r_victim;

endmodule

`default_nettype wire

>>> sv/lfr_checker.sv
`default_nettype none

module lfr_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire logic                        o_in_stall,
    input wire logic                        i_action,
    input wire logic [lfr_pkg::FRAME_W-1:0] i_frame_index,
    input wire logic                        o_out_valid,
    input wire logic                        i_out_stall,
    input wire logic [lfr_pkg::FRAME_W-1:0] o_victim_frame
);
    import lfr_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    // A held result word keeps its frame
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_victim_frame))
        else $error("result word changed while stalled");

    // Input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    // A victim request reaches the output once the slot is free
    a_victim_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_action == ACT_VICTIM)) ##1 !(o_out_valid && i_out_stall)
        |=> o_out_valid)
        else $error("victim result missing");

    // Reset empties the output
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid after reset");

endmodule

bind lru_frame_replacement lfr_checker u_lfr_checker (.*);

`default_nettype wire

>>> sim/lru_frame_replacement_chk.sv
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard for the LRU frame policy: it watches both channels, keeps its
// own recency order and compares every victim word against it.
module lru_frame_replacement_chk #(
    parameter int FRAME_CNT = lfr_pkg::DEF_FRAME_CNT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic                        i_action,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_frame_index,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic [lfr_pkg::FRAME_W-1:0] i_victim_frame,
    output int                               o_errors,
    output int                               o_pending,
    output int                               o_words,
    output int                               o_results
);

    import lfr_pkg::*;

    localparam int RANK_W = (FRAME_CNT > 1) ? $clog2(FRAME_CNT) : 1;

    typedef logic [RANK_W-1:0] t_rank;

    // recency rank per frame: 0 = least recent, FRAME_CNT-1 = most recent
    t_rank              rank_of [FRAME_CNT];
    // victim frames still owed by the block, oldest first
    logic [FRAME_W-1:0] victim_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] lru chk: %s", $time, what);
        o_errors++;
    endtask

    // frame holding rank 0
    function automatic int unsigned find_lru();
        int unsigned lru;
        lru = 0;
        for (int f = FRAME_CNT - 1; f >= 0; f--) begin
            if (rank_of[f] == '0) lru = f;
        end
        return lru;
    endfunction

    // move a frame to most recent; everything newer than it slides down one
    task automatic promote(input int unsigned frame);
        t_rank old_rank;
        old_rank = rank_of[frame];
        for (int g = 0; g < FRAME_CNT; g++) begin
            if (rank_of[g] > old_rank) rank_of[g] = rank_of[g] - 1'b1;
        end
        rank_of[frame] = t_rank'(FRAME_CNT - 1);
    endtask

    always @(posedge i_clk) begin : track
        logic [FRAME_W-1:0] want;
        int unsigned        victim;
        if (!i_rst_n) begin
            for (int f = 0; f < FRAME_CNT; f++) rank_of[f] = t_rank'(f);
            victim_q.delete();
            o_errors  = 0;
            o_words   = 0;
            o_results = 0;
        end else begin
            // result side first: a request accepted now cannot answer now
            if (i_out_valid && !i_out_stall) begin
                o_results++;
                if (victim_q.size() == 0) begin
                    report_mismatch($sformatf("victim word %0d with no request waiting",
                                              i_victim_frame));
                end else begin
                    want = victim_q.pop_front();
                    if (i_victim_frame !== want)
                        report_mismatch($sformatf("victim frame %0d, expected %0d",
                                                  i_victim_frame, want));
                end
            end
            // request side
            if (i_in_valid && !i_in_stall) begin
                o_words++;
                if (i_action == ACT_VICTIM) begin
                    victim = find_lru();
                    promote(victim);
                    victim_q.push_back(FRAME_W'(victim));
                end else if (int'(i_frame_index) < FRAME_CNT) begin
                    promote(i_frame_index);
                end
            end
        end
        o_pending <= victim_q.size();
    end

endmodule

`default_nettype wire

>>> sim/lru_frame_replacement_tb.sv
`timescale 1ns / 100ps
`default_nettype none

module lru_frame_replacement_tb;

    import lfr_pkg::*;

    localparam int FRAME_CNT   = DEF_FRAME_CNT;
    localparam int FRAME_MAX   = (1 << FRAME_W) - 1;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 200;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_action;
    logic [FRAME_W-1:0] i_frame_index;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [FRAME_W-1:0] o_victim_frame;

    int chk_errors;
    int chk_pending;
    int chk_words;
    int chk_results;

    int send_idle_pct = 38;
    int recv_pct      = 62;
    int hold_len      = 0;
    int idle_cnt      = 0;
    int stall_run     = 0;
    int max_stall     = 0;

    lru_frame_replacement #(
        .FRAME_CNT(FRAME_CNT)
    ) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_frame_index  (i_frame_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_victim_frame (o_victim_frame)
    );

    lru_frame_replacement_chk #(
        .FRAME_CNT(FRAME_CNT)
    ) u_chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_frame_index  (i_frame_index),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_victim_frame (o_victim_frame),
        .o_errors       (chk_errors),
        .o_pending      (chk_pending),
        .o_words        (chk_words),
        .o_results      (chk_results)
    );

    // 4 ns clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: random stall, or one long hold-off when asked for
    initial begin : receiver
        int n;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_len != 0) begin
                n        = hold_len;
                hold_len = 0;
                i_out_stall <= 1'b1;
                repeat (n - 1) @(posedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_pct);
            end
        end
    end

    // watchdog on handshake progress; also tracks the longest input stall
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_stall) stall_run++;
        else stall_run = 0;
        if (stall_run > max_stall) max_stall = stall_run;
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cnt = 0;
        end else begin
            idle_cnt++;
        end
        if (idle_cnt >= IDLE_LIMIT) begin
            $display("no handshake for %0d cycles", IDLE_LIMIT);
            $display("[lru_frame_replacement] ERROR");
            $finish;
        end
    end

    // offer one word, with random idle cycles ahead of it; returns once accepted
    task automatic send_word(input logic act, input logic [FRAME_W-1:0] frame);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_frame_index <= frame;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // random mix; the victim share drifts every 50 words, and some accesses
    // repeat the previous frame to hit the already-most-recent case
    task automatic send_random(input int count);
        logic [FRAME_W-1:0] last_frame;
        logic [FRAME_W-1:0] fr;
        int                 vic_pct;
        last_frame = '0;
        vic_pct    = 30;
        for (int k = 0; k < count; k++) begin
            if (k % 50 == 0) vic_pct = $urandom_range(5, 60);
            if ($urandom_range(99) < vic_pct) begin
                send_word(ACT_VICTIM, FRAME_W'($urandom));
            end else begin
                if ($urandom_range(99) < 20) fr = last_frame;
                else fr = FRAME_W'($urandom_range(FRAME_MAX));
                last_frame = fr;
                send_word(ACT_ACCESS, fr);
            end
        end
    endtask

    // stop offering until every victim word owed has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_action      <= ACT_ACCESS;
        i_frame_index <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: victims from reset order, extremes, most-recent access
        send_word(ACT_VICTIM, 4'd0);
        send_word(ACT_VICTIM, FRAME_W'(FRAME_MAX));
        send_word(ACT_ACCESS, 4'd1);
        send_word(ACT_ACCESS, FRAME_W'(FRAME_MAX));
        send_word(ACT_ACCESS, FRAME_W'(FRAME_MAX));
        send_word(ACT_ACCESS, 4'd0);
        send_word(ACT_VICTIM, 4'b1010);
        send_word(ACT_ACCESS, 4'd3);
        send_word(ACT_VICTIM, 4'b0101);
        send_word(ACT_ACCESS, 4'd8);
        send_word(ACT_ACCESS, 4'b0101);
        send_word(ACT_ACCESS, 4'b1010);
        send_word(ACT_VICTIM, 4'd0);
        send_word(ACT_VICTIM, 4'd0);
        send_word(ACT_VICTIM, FRAME_W'(FRAME_MAX));
        // out-of-range frames, if the field can name any
        for (int f = FRAME_CNT; f <= FRAME_MAX; f++) send_word(ACT_ACCESS, f[FRAME_W-1:0]);
        // eight more victims in a row, with random frame fields
        for (int k = 0; k < 8; k++) send_word(ACT_VICTIM, FRAME_W'($urandom));

        // receiver idles more than sender
        send_random(330);
        drain();
        send_random(20);

        // sender idles more than receiver
        send_idle_pct = 62;
        recv_pct      = 38;
        send_random(340);

        // no idling, with one long output hold-off while words keep coming
        send_idle_pct = 0;
        recv_pct      = 0;
        send_random(150);
        hold_len = HOLD_CYCLES;
        send_random(60);
        send_random(150);

        drain();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d request words and %0d victim words under three idle mixes,",
                 chk_words, chk_results);
        $display("with input stalled up to %0d cycles behind a %0d-cycle output hold-off.",
                 max_stall, HOLD_CYCLES);
        if (chk_errors == 0) begin
            $display("[lru_frame_replacement] OK");
        end else begin
            $display("[lru_frame_replacement] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/lfr_pkg.sv
sv/lru_frame_replacement.sv
sv/lfr_checker.sv
sim/lru_frame_replacement_chk.sv
sim/lru_frame_replacement_tb.sv
